@@ sv/npe_pkg.sv @@
// ----------------------------------------------------------------------------
// npe_pkg
// Opcodes and controller/datapath interface types for the permutation
// enumerator.
// ----------------------------------------------------------------------------
package npe_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_EMIT   = 2'd2;

	typedef enum logic [1:0] {
		RA_K  = 2'd0,
		RA_LO = 2'd1,
		RA_HI = 2'd2
	} ra_sel_t;

	typedef struct packed {
		logic    len_clr;
		logic    len_app;
		logic    emit_init;
		logic    out_load;
		logic    out_empty;
		logic    k_inc;
		logic    k_dec;
		ra_sel_t ra_sel;
		logic    wr_piv;
		logic    wr_k;
		logic    rev_init_next;
		logic    rev_init_all;
		logic    tmp_load;
		logic    wr_lo;
		logic    wr_hi;
		logic    rev_step;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic out_free;
		logic k_last;
		logic asc_now;
		logic found;
		logic rev_done;
	} sts_t;

endpackage

@@ sv/npe_ctrl.sv @@
// ----------------------------------------------------------------------------
// npe_ctrl
// Sequencer: input transactions, emit streaming, successor search, swap and
// suffix reversal.
// ----------------------------------------------------------------------------
module npe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  npe_pkg::sts_t sts,
	output npe_pkg::cmd_t cmd
);
	import npe_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_EMPTY = 11'b000_0000_0010,
		S_RD    = 11'b000_0000_0100,
		S_ST    = 11'b000_0000_1000,
		S_FR    = 11'b000_0001_0000,
		S_FC    = 11'b000_0010_0000,
		S_SW    = 11'b000_0100_0000,
		S_RV0   = 11'b000_1000_0000,
		S_RV1   = 11'b001_0000_0000,
		S_RV2   = 11'b010_0000_0000,
		S_RV3   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.ra_sel = RA_K;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (opcode)
						OP_CLEAR:  cmd.len_clr = 1'b1;
						OP_APPEND: cmd.len_app = 1'b1;
						OP_EMIT: begin
							if (sts.len_zero) begin
								state_d = S_EMPTY;
							end else begin
								cmd.emit_init = 1'b1;
								state_d = S_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_empty = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				state_d = S_ST;
			end
			S_ST: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.k_last) begin
						if (sts.asc_now) begin
							state_d = S_FR;
						end else begin
							cmd.rev_init_all = 1'b1;
							state_d = S_RV0;
						end
					end else begin
						cmd.k_inc = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_FR: begin
				state_d = S_FC;
			end
			S_FC: begin
				if (sts.found) begin
					cmd.wr_piv = 1'b1;
					state_d = S_SW;
				end else begin
					cmd.k_dec = 1'b1;
					state_d = S_FR;
				end
			end
			S_SW: begin
				cmd.wr_k = 1'b1;
				cmd.rev_init_next = 1'b1;
				state_d = S_RV0;
			end
			S_RV0: begin
				cmd.ra_sel = RA_LO;
				if (sts.rev_done) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_RV1;
				end
			end
			S_RV1: begin
				cmd.ra_sel = RA_HI;
				cmd.tmp_load = 1'b1;
				state_d = S_RV2;
			end
			S_RV2: begin
				cmd.wr_lo = 1'b1;
				state_d = S_RV3;
			end
			S_RV3: begin
				cmd.wr_hi = 1'b1;
				cmd.rev_step = 1'b1;
				state_d = S_RV0;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/npe_dp.sv @@
// ----------------------------------------------------------------------------
// npe_dp
// Byte store, length and index registers, pivot tracking and the output
// register.
// ----------------------------------------------------------------------------
module npe_dp #(
	parameter int MAX_LEN = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  npe_pkg::cmd_t cmd,
	output npe_pkg::sts_t sts,
	input  logic [7:0]    in_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          is_last,
	output logic          is_empty,
	output logic          has_next
);
	import npe_pkg::*;

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);

	logic [7:0]    mem [MAX_LEN];
	logic [7:0]    rdata_q;
	logic [AW-1:0] raddr;

	logic [LW-1:0] len_q;
	logic [LW-1:0] len_m1;
	logic [AW-1:0] k_q, lo_q, hi_q, piv_q;
	logic [7:0]    prev_q, pivval_q, tmp_q;
	logic          asc_q;
	logic          asc_here;

	logic          ov_q;
	logic [7:0]    ob_q;
	logic          last_q, empty_q, next_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	assign len_m1   = len_q - LW'(1);
	assign asc_here = (k_q != '0) && (prev_q < rdata_q);

	assign sts.len_zero = (len_q == '0);
	assign sts.out_free = !ov_q || out_ready;
	assign sts.k_last   = (k_q == len_m1[AW-1:0]);
	assign sts.asc_now  = asc_q || asc_here;
	assign sts.found    = (rdata_q > pivval_q);
	assign sts.rev_done = (lo_q >= hi_q);

	always_comb begin
		case (cmd.ra_sel)
			RA_K:    raddr = k_q;
			RA_LO:   raddr = lo_q;
			RA_HI:   raddr = hi_q;
			default: raddr = k_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = k_q;
		wdata = rdata_q;
		if (cmd.len_app && (len_q != LW'(MAX_LEN))) begin
			we    = 1'b1;
			waddr = len_q[AW-1:0];
			wdata = in_byte;
		end else if (cmd.wr_piv) begin
			we    = 1'b1;
			waddr = piv_q;
			wdata = rdata_q;
		end else if (cmd.wr_k) begin
			we    = 1'b1;
			waddr = k_q;
			wdata = pivval_q;
		end else if (cmd.wr_lo) begin
			we    = 1'b1;
			waddr = lo_q;
			wdata = rdata_q;
		end else if (cmd.wr_hi) begin
			we    = 1'b1;
			waddr = hi_q;
			wdata = tmp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ov_q  <= 1'b0;
			asc_q <= 1'b0;
		end else begin
			if (cmd.len_clr) begin
				len_q <= '0;
			end else if (cmd.len_app && (len_q != LW'(MAX_LEN))) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.out_load || cmd.out_empty) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cmd.emit_init) begin
				asc_q <= 1'b0;
			end else if (cmd.out_load && asc_here) begin
				asc_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_init) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + AW'(1);
		end else if (cmd.k_dec) begin
			k_q <= k_q - AW'(1);
		end
		if (cmd.out_load) begin
			prev_q <= rdata_q;
			if (asc_here) begin
				piv_q    <= k_q - AW'(1);
				pivval_q <= prev_q;
			end
		end
		if (cmd.rev_init_all) begin
			lo_q <= '0;
			hi_q <= len_m1[AW-1:0];
		end else if (cmd.rev_init_next) begin
			lo_q <= piv_q + AW'(1);
			hi_q <= len_m1[AW-1:0];
		end else if (cmd.rev_step) begin
			lo_q <= lo_q + AW'(1);
			hi_q <= hi_q - AW'(1);
		end
		if (cmd.tmp_load) begin
			tmp_q <= rdata_q;
		end
		if (cmd.out_load) begin
			ob_q    <= rdata_q;
			last_q  <= sts.k_last;
			empty_q <= 1'b0;
			next_q  <= sts.k_last && sts.asc_now;
		end else if (cmd.out_empty) begin
			ob_q    <= '0;
			last_q  <= 1'b1;
			empty_q <= 1'b1;
			next_q  <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign is_last   = last_q;
	assign is_empty  = empty_q;
	assign has_next  = next_q;

endmodule

@@ sv/next_permutation_enumerator.sv @@
// ----------------------------------------------------------------------------
// next_permutation_enumerator
// Clear/append: one transaction per cycle while idle. Emit of n bytes: each byte
// is read in RD and loaded into the output register in ST once it is free; an empty
// store gives one empty beat. Then the successor search (FR/FC per compare), the
// swap (SW) and the reversal (RV0 to RV3 per swapped pair, RV0 to finish) run.
// One emit at a time; a new transaction is taken once the store is back in
// place. Reset: length zero, sequencer idle, store contents undefined.
// ----------------------------------------------------------------------------
module next_permutation_enumerator #(
	parameter int MAX_LEN = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_last,
	output logic       is_empty,
	output logic       has_next
);
	import npe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	npe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	npe_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.is_last   (is_last),
		.is_empty  (is_empty),
		.has_next  (has_next)
	);

endmodule

@@ bench/next_permutation_enumerator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// next_permutation_enumerator_test
// Self-checking bench for the permutation enumerator. A short stimulus table
// hits the empty store, single byte, byte zero, duplicates, wrap to ascending
// order, overfill and the unused opcode. After that come random
// clear/append/emit runs with some noise mixed in. Every emitted byte is
// checked against a behavioral mirror of the store, with random stalls on
// both handshakes.
// ----------------------------------------------------------------------------
module next_permutation_enumerator_test;
	import npe_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int ITEM_GOAL = 350;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       empty;
		logic       more;
	} beat_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		int         reps;
		bit         typed;
		beat_t      want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] opcode;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       is_last;
	logic       is_empty;
	logic       has_next;

	logic [7:0] mirror_store [STORE_DEPTH];
	int         mirror_len;
	beat_t      awaited [$];
	int         errors;
	int         items;
	bit         steady;

	stim_row_t script [24] = '{
		'{OP_EMIT,    8'h00, 1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
		'{OP_APPEND,  8'hFF, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
		'{OP_EMIT,    8'hA5, 1,  1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
		'{OP_IGNORED, 8'h55, 1,  1'b0, '0},
		'{OP_CLEAR,   8'hFF, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
		'{OP_APPEND,  8'h00, 1,  1'b0, '0},
		'{OP_APPEND,  8'h01, 1,  1'b0, '0},
		'{OP_APPEND,  8'h80, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b0, '0},
		'{OP_APPEND,  8'h80, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 3,  1'b0, '0},
		'{OP_CLEAR,   8'h00, 1,  1'b0, '0},
		'{OP_APPEND,  8'hAA, 1,  1'b0, '0},
		'{OP_APPEND,  8'h55, 1,  1'b0, '0},
		'{OP_APPEND,  8'h0F, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b0, '0},
		'{OP_EMIT,    8'h00, 1,  1'b0, '0},
		'{OP_CLEAR,   8'h00, 1,  1'b0, '0},
		'{OP_APPEND,  8'h7E, 17, 1'b0, '0},
		'{OP_EMIT,    8'h00, 2,  1'b0, '0},
		'{OP_CLEAR,   8'h00, 1,  1'b0, '0}
	};

	next_permutation_enumerator #(
		.MAX_LEN(STORE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.is_last(is_last),
		.is_empty(is_empty),
		.has_next(has_next)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void swap_entries(input int a, input int b);
		logic [7:0] t;
		t = mirror_store[a];
		mirror_store[a] = mirror_store[b];
		mirror_store[b] = t;
	endfunction

	function automatic void reverse_span(input int lo, input int hi);
		while (lo < hi) begin
			swap_entries(lo, hi);
			lo++;
			hi--;
		end
	endfunction

	// Moves the mirror to the next arrangement; 0 when it wrapped to ascending.
	function automatic bit step_arrangement();
		int n;
		int i;
		int k;
		n = mirror_len;
		if (n < 2) return 1'b0;
		for (int j = n - 1; j > 0; j--) begin
			i = j - 1;
			if (mirror_store[i] < mirror_store[j]) begin
				k = n - 1;
				while (k > i && mirror_store[k] <= mirror_store[i]) k--;
				swap_entries(k, i);
				reverse_span(j, n - 1);
				return 1'b1;
			end
		end
		reverse_span(0, n - 1);
		return 1'b0;
	endfunction

	task automatic forecast_beats(input logic [1:0] op, input logic [7:0] data,
			ref beat_t beats[$]);
		case (op)
			OP_CLEAR: begin
				mirror_len = 0;
			end
			OP_APPEND: begin
				if (mirror_len < STORE_DEPTH) begin
					mirror_store[mirror_len] = data;
					mirror_len++;
				end
			end
			OP_EMIT: begin
				if (mirror_len == 0) begin
					beats.insert(beats.size(), beat_t'{8'h00, 1'b1, 1'b1, 1'b0});
				end else begin
					for (int k = 0; k < mirror_len; k++)
						beats.insert(beats.size(),
							beat_t'{mirror_store[k], k == mirror_len - 1, 1'b0, 1'b0});
					beats[beats.size() - 1].more = step_arrangement();
				end
			end
			default: ;
		endcase
	endtask

	task automatic send(input logic [1:0] op, input logic [7:0] data, input bit typed,
			input beat_t want);
		beat_t fresh [$];
		in_valid <= 1'b1;
		opcode <= op;
		in_byte <= data;
		do @(posedge clk); while (!in_ready);
		forecast_beats(op, data, fresh);
		if (typed) awaited.insert(awaited.size(), want);
		else foreach (fresh[i]) awaited.insert(awaited.size(), fresh[i]);
		if (op != OP_IGNORED) items++;
		if (!steady && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_plain(input logic [1:0] op, input logic [7:0] data);
		send(op, data, 1'b0, '0);
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= steady || $urandom_range(0, 99) >= 29;
		end
	end

	always @(posedge clk) begin
		beat_t seen;
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = '{out_byte, is_last, is_empty, has_next};
			if (awaited.size() == 0) begin
				note_mismatch("unexpected transaction", int'(seen), 0);
			end else begin
				want = awaited.pop_front();
				if (seen.value !== want.value)
					note_mismatch("out_byte", int'(seen.value), int'(want.value));
				if (seen.last !== want.last)
					note_mismatch("is_last", int'(seen.last), int'(want.last));
				if (seen.empty !== want.empty)
					note_mismatch("is_empty", int'(seen.empty), int'(want.empty));
				if (seen.more !== want.more)
					note_mismatch("has_next", int'(seen.more), int'(want.more));
			end
		end
	end

	initial begin
		int len;
		int emits;
		int lo;
		int hi;
		bit drained;
		errors = 0;
		items = 0;
		mirror_len = 0;
		steady = 1'b0;
		drained = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_CLEAR;
		in_byte <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r])
			repeat (script[r].reps) send(script[r].op, script[r].data, script[r].typed,
				script[r].want);

		while (items < ITEM_GOAL) begin
			steady = items >= 120 && items < 200;
			if (!drained && items >= 260) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				while (awaited.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 80) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(13, 17) : $urandom_range(0, 6);
				if ($urandom_range(0, 1)) begin
					lo = $urandom_range(1, 253);
					hi = lo + 2;
				end else begin
					lo = 1;
					hi = 255;
				end
				if ($urandom_range(0, 3) != 0)
					send_plain(OP_CLEAR, 8'($urandom_range(0, 255)));
				repeat (len) send_plain(OP_APPEND, 8'($urandom_range(lo, hi)));
				emits = (len <= 4 && $urandom_range(0, 1)) ? $urandom_range(1, 26)
					: $urandom_range(1, 4);
				repeat (emits) begin
					if ($urandom_range(0, 9) == 0)
						send_plain(OP_IGNORED, 8'($urandom_range(0, 255)));
					send_plain(OP_EMIT, 8'($urandom_range(0, 255)));
				end
			end else begin
				send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (awaited.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && awaited.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
